// ----- src/pidc_pkg.sv -----
// pidc_pkg: shared constants, register indexes, op codes and state types
// of the pid position controller; used by pid_position_controller.sv
// no dependencies
`default_nettype none

package pidc_pkg;

	// default fixed-point format and accumulator width
	localparam int FRAC_BITS_DEF = 24;
	localparam int ACC_WIDTH_DEF = 48;

	// fixed field widths
	localparam int DATA_W     = 32;
	localparam int GAIN_W     = 48;
	localparam int BIAS_W     = 26;
	localparam int SCALE_W    = 31;
	localparam int ERR_W      = 27;
	localparam int OP_W       = 2;
	localparam int CFG_W      = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 64;

	// register values after reset
	localparam logic signed [DATA_W-1:0] IN_MIN_RST        = -32'sd13421773;
	localparam logic        [SCALE_W-1:0] IN_RECIP_RST     = 31'd10485760;
	localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST     = '0;
	localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST    = '0;
	localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST    = '0;
	localparam logic signed [BIAS_W-1:0] BIAS_RST          = '0;
	localparam logic        [SCALE_W-1:0] OUT_SCALE_RST    = 31'd8389;
	localparam logic signed [DATA_W-1:0] OUT_OFFSET_RST    = '0;

	// drive saturation limits
	localparam logic signed [DATA_W-1:0] I32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] I32_MIN = 32'sh8000_0000;

	// request op codes
	typedef enum logic [OP_W-1:0] {
		OP_CENTERED = 2'd0,
		OP_SPAN     = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_MIN      = 3'd0,
		REG_IN_RECIP    = 3'd1,
		REG_PROP_GAIN   = 3'd2,
		REG_INTEG_GAIN  = 3'd3,
		REG_DERIV_GAIN  = 3'd4,
		REG_BIAS        = 3'd5,
		REG_OUT_SCALE   = 3'd6,
		REG_OUT_OFFSET  = 3'd7
	} reg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_POST,
		ST_SAT,
		ST_STEP,
		ST_INNER,
		ST_NORM,
		ST_DONE
	} st_t;

	// which product the serial multiplier is working on
	typedef enum logic [2:0] {
		PH_SCALE_SP,
		PH_SCALE_PV,
		PH_DERIV,
		PH_INTEG,
		PH_PROP,
		PH_DRIVE
	} ph_t;

endpackage

`default_nettype wire

// ----- src/pid_position_controller.sv -----
// pid_position_controller: sampled PID controller with anti-windup, built
// around one shift-add multiplier that takes one multiplier bit per cycle
// depends on pidc_pkg
//
// channel   dir   handshake            payload
// s_        in    s_tvalid/s_tready    s_tdata {process_value, set_point}, s_tuser op
// m_        out   m_tvalid/m_tready    m_tdata {error_value, pegged_low, pegged_high, drive}
// cfg_      in    cfg_we               cfg_index, cfg_data
//
// a compute request runs six products through the serial multiplier
// (MW = max(ACC_WIDTH, 48)), each through the states LOAD, MUL, POST, SAT
// and STEP, and its result is loaded into the output register in DONE
// a clear request and an unused op code are taken in idle and give no result
// the next request is taken once the result sits in the output register,
// and a stalled output only holds the sequencer in its final state
// arst_n clears the controller state and loads the register defaults
`default_nettype none

module pid_position_controller #(
	parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF,
	parameter int ACC_WIDTH = pidc_pkg::ACC_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [31:0] set_point, [63:32] process_value
	input  logic [pidc_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] op
	input  logic [pidc_pkg::OP_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] drive, [32] pegged_high, [33] pegged_low, [60:34] error_value, [63:61] zero
	output logic [pidc_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pidc_pkg::CFG_W-1:0]       cfg_data
);

	localparam int NW  = FRAC_BITS + 3;
	localparam int SCW = FRAC_BITS + 2;
	localparam int LNW = (pidc_pkg::BIAS_W > SCW) ? pidc_pkg::BIAS_W : SCW;
	localparam int MW  = (ACC_WIDTH > pidc_pkg::GAIN_W) ? ACC_WIDTH : pidc_pkg::GAIN_W;
	localparam int PW  = 2 * MW;
	localparam int QW  = PW + 1 - FRAC_BITS;
	localparam int SW  = ((ACC_WIDTH > NW) ? ACC_WIDTH : NW) + 2;
	localparam int CW  = $clog2(MW);
	localparam int DW  = pidc_pkg::DATA_W + 1;

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_ONE =
		{{(ACC_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [SW-1:0] SW_ACC_MAX = SW'(ACC_MAX);
	localparam logic signed [SW-1:0] SW_ACC_MIN = SW'(ACC_MIN);
	localparam logic signed [SW-1:0] SW_ONE     = SW'(ACC_ONE);
	localparam logic signed [SW-1:0] SW_I32_MAX = SW'(pidc_pkg::I32_MAX);
	localparam logic signed [SW-1:0] SW_I32_MIN = SW'(pidc_pkg::I32_MIN);

	function automatic logic signed [SW-1:0] clamp_sw(
		input logic signed [SW-1:0] v,
		input logic signed [SW-1:0] lo,
		input logic signed [SW-1:0] hi
	);
		logic signed [SW-1:0] r;
		if (v > hi)
			r = hi;
		else if (v < lo)
			r = lo;
		else
			r = v;
		return r;
	endfunction

	// configuration registers
	logic signed [pidc_pkg::DATA_W-1:0]  in_min_q;
	logic        [pidc_pkg::SCALE_W-1:0] in_recip_q;
	logic signed [pidc_pkg::GAIN_W-1:0]  prop_gain_q;
	logic signed [pidc_pkg::GAIN_W-1:0]  integ_gain_q;
	logic signed [pidc_pkg::GAIN_W-1:0]  deriv_gain_q;
	logic signed [pidc_pkg::BIAS_W-1:0]  bias_q;
	logic        [pidc_pkg::SCALE_W-1:0] out_scale_q;
	logic signed [pidc_pkg::DATA_W-1:0]  out_offset_q;

	// controller state
	logic signed [ACC_WIDTH-1:0]         integ_q;
	logic signed [LNW-1:0]               last_norm_q;
	logic signed [pidc_pkg::DATA_W-1:0]  last_meas_q;

	// sequencer
	pidc_pkg::st_t state_q, state_d;
	pidc_pkg::ph_t phase_q;
	logic [CW-1:0] cnt_q;
	logic          m_tvalid_q;
	logic          in_acc;
	logic          in_compute;
	logic          load_out;
	pidc_pkg::op_t in_op;
	logic signed [pidc_pkg::DATA_W-1:0] in_sp;
	logic signed [pidc_pkg::DATA_W-1:0] in_pv;

	// per-request operands
	logic                               centered_q;
	logic signed [pidc_pkg::DATA_W-1:0] pv_q;
	logic signed [DW-1:0]               dsp_q;
	logic signed [DW-1:0]               dpv_q;
	logic signed [DW-1:0]               dmeas_q;

	// serial multiplier
	logic signed [MW-1:0] opa, opb;
	logic        [MW-1:0] amag, bmag;
	logic        [MW-1:0] mul_a_q;
	logic        [MW-1:0] mul_hi_q;
	logic        [MW-1:0] mul_lo_q;
	logic                 mul_neg_q;
	logic        [MW:0]   mul_sum;
	logic        [PW-1:0] prod;
	logic signed [PW:0]   prod_q;

	// product saturation
	logic signed [ACC_WIDTH-1:0] sat_lo, sat_hi;
	logic signed [QW-1:0]        q_val, q_lo, q_hi, q_sat;
	logic signed [ACC_WIDTH-1:0] mres_q;

	// intermediate results
	logic signed [SCW-1:0]       ssp_q;
	logic signed [NW-1:0]        err_q;
	logic signed [ACC_WIDTH-1:0] m2_q;
	logic signed [ACC_WIDTH-1:0] inner_q;
	logic signed [ACC_WIDTH-1:0] nraw_q;
	logic                        peg_hi_q, peg_lo_q;
	logic signed [pidc_pkg::DATA_W-1:0] drv_q;
	logic signed [SW-1:0]        lo_sw;
	logic                        hold;
	logic signed [SW-1:0]        off_sw;

	// output register
	logic signed [pidc_pkg::DATA_W-1:0] out_drive_q;
	logic                               out_hi_q, out_lo_q;
	logic        [pidc_pkg::ERR_W-1:0]  out_err_q;
	logic signed [63:0]                 err_ext;

	// request decode
	assign in_op      = pidc_pkg::op_t'(s_tuser);
	assign in_sp      = s_tdata[pidc_pkg::DATA_W-1:0];
	assign in_pv      = s_tdata[2*pidc_pkg::DATA_W-1:pidc_pkg::DATA_W];
	assign in_acc     = s_tvalid && s_tready;
	assign in_compute = (in_op == pidc_pkg::OP_CENTERED) || (in_op == pidc_pkg::OP_SPAN);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pidc_pkg::ST_IDLE: begin
				if (s_tvalid && in_compute)
					state_d = pidc_pkg::ST_LOAD;
			end
			pidc_pkg::ST_LOAD:  state_d = pidc_pkg::ST_MUL;
			pidc_pkg::ST_MUL: begin
				if (cnt_q == CW'(MW-1))
					state_d = pidc_pkg::ST_POST;
			end
			pidc_pkg::ST_POST:  state_d = pidc_pkg::ST_SAT;
			pidc_pkg::ST_SAT:   state_d = pidc_pkg::ST_STEP;
			pidc_pkg::ST_STEP: begin
				unique case (phase_q)
					pidc_pkg::PH_INTEG: state_d = pidc_pkg::ST_INNER;
					pidc_pkg::PH_PROP:  state_d = pidc_pkg::ST_NORM;
					pidc_pkg::PH_DRIVE: state_d = pidc_pkg::ST_DONE;
					default:            state_d = pidc_pkg::ST_LOAD;
				endcase
			end
			pidc_pkg::ST_INNER: state_d = pidc_pkg::ST_LOAD;
			pidc_pkg::ST_NORM:  state_d = pidc_pkg::ST_LOAD;
			pidc_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready)
					state_d = pidc_pkg::ST_IDLE;
			end
			default: state_d = pidc_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = (state_q == pidc_pkg::ST_IDLE);
		load_out = (state_q == pidc_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
	end

	// lower clamp limit and output offset of the current mode, and anti-windup hold
	always_comb begin
		lo_sw  = centered_q ? -SW_ONE : '0;
		off_sw = centered_q ? '0 : SW'(out_offset_q);
		hold   = ((SW'(last_norm_q) >= SW_ONE) && (err_q > 0)) ||
		         ((SW'(last_norm_q) <= lo_sw) && (err_q < 0));
	end

	// multiplier operand select and magnitudes
	always_comb begin
		unique case (phase_q)
			pidc_pkg::PH_SCALE_SP: begin
				opa = MW'(dsp_q);
				opb = MW'($signed({1'b0, in_recip_q}));
			end
			pidc_pkg::PH_SCALE_PV: begin
				opa = MW'(dpv_q);
				opb = MW'($signed({1'b0, in_recip_q}));
			end
			pidc_pkg::PH_DERIV: begin
				opa = MW'(deriv_gain_q);
				opb = MW'(dmeas_q);
			end
			pidc_pkg::PH_INTEG: begin
				opa = MW'(integ_gain_q);
				opb = MW'(integ_q);
			end
			pidc_pkg::PH_PROP: begin
				opa = MW'(prop_gain_q);
				opb = MW'(inner_q);
			end
			pidc_pkg::PH_DRIVE: begin
				opa = MW'(last_norm_q);
				opb = MW'($signed({1'b0, out_scale_q}));
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		amag = opa[MW-1] ? MW'(-opa) : opa;
		bmag = opb[MW-1] ? MW'(-opb) : opb;
	end

	// one shift-add step
	assign mul_sum = {1'b0, mul_hi_q} + (mul_lo_q[0] ? {1'b0, mul_a_q} : '0);
	assign prod    = {mul_hi_q, mul_lo_q};

	// floor shift and saturation of the signed product
	always_comb begin
		if (phase_q == pidc_pkg::PH_SCALE_SP || phase_q == pidc_pkg::PH_SCALE_PV) begin
			sat_lo = centered_q ? -ACC_ONE : '0;
			sat_hi = ACC_ONE;
		end else begin
			sat_lo = ACC_MIN;
			sat_hi = ACC_MAX;
		end
		q_val = prod_q[PW:FRAC_BITS];
		q_lo  = QW'(sat_lo);
		q_hi  = QW'(sat_hi);
		if (q_val > q_hi)
			q_sat = q_hi;
		else if (q_val < q_lo)
			q_sat = q_lo;
		else
			q_sat = q_val;
	end

	// control state, configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pidc_pkg::ST_IDLE;
			phase_q      <= pidc_pkg::PH_SCALE_SP;
			cnt_q        <= '0;
			m_tvalid_q   <= 1'b0;
			in_min_q     <= pidc_pkg::IN_MIN_RST;
			in_recip_q   <= pidc_pkg::IN_RECIP_RST;
			prop_gain_q  <= pidc_pkg::PROP_GAIN_RST;
			integ_gain_q <= pidc_pkg::INTEG_GAIN_RST;
			deriv_gain_q <= pidc_pkg::DERIV_GAIN_RST;
			bias_q       <= pidc_pkg::BIAS_RST;
			out_scale_q  <= pidc_pkg::OUT_SCALE_RST;
			out_offset_q <= pidc_pkg::OUT_OFFSET_RST;
			integ_q      <= '0;
			last_norm_q  <= '0;
			last_meas_q  <= '0;
		end else begin
			state_q <= state_d;

			// register writes
			if (cfg_we) begin
				unique case (pidc_pkg::reg_t'(cfg_index))
					pidc_pkg::REG_IN_MIN:     in_min_q     <= cfg_data[pidc_pkg::DATA_W-1:0];
					pidc_pkg::REG_IN_RECIP:   in_recip_q   <= cfg_data[pidc_pkg::SCALE_W-1:0];
					pidc_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data[pidc_pkg::GAIN_W-1:0];
					pidc_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_data[pidc_pkg::GAIN_W-1:0];
					pidc_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data[pidc_pkg::GAIN_W-1:0];
					pidc_pkg::REG_BIAS:       bias_q       <= cfg_data[pidc_pkg::BIAS_W-1:0];
					pidc_pkg::REG_OUT_SCALE:  out_scale_q  <= cfg_data[pidc_pkg::SCALE_W-1:0];
					pidc_pkg::REG_OUT_OFFSET: out_offset_q <= cfg_data[pidc_pkg::DATA_W-1:0];
				endcase
			end

			// sequencer bookkeeping and state updates
			unique case (state_q)
				pidc_pkg::ST_IDLE: begin
					if (in_acc && in_op == pidc_pkg::OP_CLEAR) begin
						integ_q     <= '0;
						last_norm_q <= LNW'(bias_q);
						last_meas_q <= in_pv;
					end
					if (in_acc && in_compute)
						phase_q <= pidc_pkg::PH_SCALE_SP;
				end
				pidc_pkg::ST_LOAD: cnt_q <= '0;
				pidc_pkg::ST_MUL:  cnt_q <= cnt_q + 1'b1;
				pidc_pkg::ST_STEP: begin
					unique case (phase_q)
						pidc_pkg::PH_SCALE_SP: phase_q <= pidc_pkg::PH_SCALE_PV;
						pidc_pkg::PH_SCALE_PV: phase_q <= pidc_pkg::PH_DERIV;
						pidc_pkg::PH_DERIV: begin
							if (!hold)
								integ_q <= ACC_WIDTH'(clamp_sw(SW'(integ_q) + SW'(err_q),
									SW_ACC_MIN, SW_ACC_MAX));
							phase_q <= pidc_pkg::PH_INTEG;
						end
						pidc_pkg::PH_INTEG:    phase_q <= pidc_pkg::PH_PROP;
						pidc_pkg::PH_PROP:     phase_q <= pidc_pkg::PH_DRIVE;
						default: ;
					endcase
				end
				pidc_pkg::ST_NORM: begin
					last_norm_q <= LNW'(clamp_sw(SW'(nraw_q), lo_sw, SW_ONE));
					last_meas_q <= pv_q;
				end
				default: ;
			endcase

			// output valid
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// operand capture with the differences taken up front
		if (in_acc && in_compute) begin
			centered_q <= (in_op == pidc_pkg::OP_CENTERED);
			pv_q       <= in_pv;
			dsp_q      <= DW'(in_sp) - DW'(in_min_q);
			dpv_q      <= DW'(in_pv) - DW'(in_min_q);
			dmeas_q    <= DW'(in_pv) - DW'(last_meas_q);
		end

		// serial multiplier: one multiplier bit per cycle
		if (state_q == pidc_pkg::ST_LOAD) begin
			mul_a_q   <= amag;
			mul_lo_q  <= bmag;
			mul_hi_q  <= '0;
			mul_neg_q <= opa[MW-1] ^ opb[MW-1];
		end
		if (state_q == pidc_pkg::ST_MUL) begin
			mul_hi_q <= mul_sum[MW:1];
			mul_lo_q <= {mul_sum[0], mul_lo_q[MW-1:1]};
		end

		// apply sign, then floor shift and saturate
		if (state_q == pidc_pkg::ST_POST)
			prod_q <= mul_neg_q ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
		if (state_q == pidc_pkg::ST_SAT)
			mres_q <= ACC_WIDTH'(q_sat);

		// per-product follow-up
		if (state_q == pidc_pkg::ST_STEP) begin
			unique case (phase_q)
				pidc_pkg::PH_SCALE_SP: ssp_q <= mres_q[SCW-1:0];
				pidc_pkg::PH_SCALE_PV:
					err_q <= NW'(ssp_q) - NW'($signed(mres_q[SCW-1:0]));
				pidc_pkg::PH_DERIV:    m2_q <= mres_q;
				pidc_pkg::PH_INTEG:
					inner_q <= ACC_WIDTH'(clamp_sw(SW'(err_q) + SW'(mres_q),
						SW_ACC_MIN, SW_ACC_MAX));
				pidc_pkg::PH_PROP: begin
					if (centered_q)
						nraw_q <= ACC_WIDTH'(clamp_sw(SW'(mres_q) + SW'(bias_q),
							SW_ACC_MIN, SW_ACC_MAX));
					else
						nraw_q <= mres_q;
				end
				pidc_pkg::PH_DRIVE:
					drv_q <= pidc_pkg::DATA_W'(clamp_sw(SW'(mres_q) + off_sw,
						SW_I32_MIN, SW_I32_MAX));
				default: ;
			endcase
		end

		// derivative term subtracted from the inner sum
		if (state_q == pidc_pkg::ST_INNER)
			inner_q <= ACC_WIDTH'(clamp_sw(SW'(inner_q) - SW'(m2_q),
				SW_ACC_MIN, SW_ACC_MAX));

		// limit flags from the unclamped normalised output
		if (state_q == pidc_pkg::ST_NORM) begin
			peg_hi_q <= (SW'(nraw_q) >= SW_ONE);
			peg_lo_q <= (SW'(nraw_q) <= lo_sw);
		end

		// output register
		if (load_out) begin
			out_drive_q <= drv_q;
			out_hi_q    <= peg_hi_q;
			out_lo_q    <= peg_lo_q;
			out_err_q   <= err_ext[pidc_pkg::ERR_W-1:0];
		end
	end

	assign err_ext  = 64'(err_q);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {
		(pidc_pkg::M_TDATA_W - pidc_pkg::ERR_W - 2 - pidc_pkg::DATA_W)'(0),
		out_err_q, out_lo_q, out_hi_q, out_drive_q
	};

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// testbench: drives set point / measurement requests into pid_position_controller
// and checks every result against an in-bench fixed-point controller copy
// depends on pidc_pkg and pid_position_controller

module testbench;

	import pidc_pkg::*;

	// fixed-point working type, wide enough for every exact product
	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		op_t               op;
		logic signed [31:0] sp;
		logic signed [31:0] pv;
	} sample_t;

	typedef struct packed {
		logic [31:0] drive;
		logic        pegged_high;
		logic        pegged_low;
		logic [26:0] error_value;
	} ctrl_out_t;

	typedef enum int {CFG_TYPICAL, CFG_WILD, CFG_TOP, CFG_BOTTOM} cfg_mode_t;

	localparam int    FRAC          = FRAC_BITS_DEF;
	localparam int    ACC           = ACC_WIDTH_DEF;
	localparam wide_t ONE_Q         = wide_t'(1) <<< FRAC;
	localparam wide_t ACC_HI        = (wide_t'(1) <<< (ACC - 1)) - 1;
	localparam wide_t ACC_LO        = -(wide_t'(1) <<< (ACC - 1));
	localparam int    SETTLE_CYCLES = 400;
	localparam int    CYCLE_LIMIT   = 3000000;
	localparam int    RANDOM_PHASES = 8;
	localparam int    PHASE_ITEMS   = 230;
	localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;
	localparam logic signed [31:0] Q_TWO = 32'sh0200_0000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0]      s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// controller copy: registers
	wide_t in_min_q = IN_MIN_RST;
	wide_t recip_q  = IN_RECIP_RST;
	wide_t prop_q   = PROP_GAIN_RST;
	wide_t integ_q  = INTEG_GAIN_RST;
	wide_t deriv_q  = DERIV_GAIN_RST;
	wide_t bias_q   = BIAS_RST;
	wide_t scale_q  = OUT_SCALE_RST;
	wide_t offset_q = OUT_OFFSET_RST;

	// controller copy: state
	wide_t integ_acc = '0;
	wide_t prev_norm = '0;
	wide_t prev_pv   = '0;

	sample_t   samples_waiting[$];
	ctrl_out_t outputs_due[$];
	sample_t   on_bus;
	ctrl_out_t next_out, want_out, got_out;
	bit        produced;
	bit        steady_flow = 1'b0;
	longint    walk_sp, walk_pv;
	int        error_count = 0;
	int        accepted_count = 0;
	int        checked_count = 0;
	int        held_count = 0;
	int        settings_count = 0;
	int        cycle_count = 0;

	pid_position_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock (the single reset is released in the stimulus phases)
	initial begin
		forever #2 clk = ~clk;
	end

	function automatic wide_t clamp(input wide_t v, input wide_t lo, input wide_t hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic wide_t sx(input logic [47:0] v, input int w);
		wide_t r;
		r = v;
		return (r <<< (128 - w)) >>> (128 - w);
	endfunction

	// exact product, floored by the fraction bits, saturated to the accumulator
	function automatic wide_t fixmul(input wide_t a, input wide_t b);
		return clamp((a * b) >>> FRAC, ACC_LO, ACC_HI);
	endfunction

	// map a raw value into span units and clamp to the mode range
	function automatic wide_t span_units(input wide_t x, input wide_t lo);
		return clamp(((x - in_min_q) * recip_q) >>> FRAC, lo, ONE_Q);
	endfunction

	// one controller sample; returns 1 when a result is produced
	function automatic bit controller_step(input sample_t s, output ctrl_out_t r);
		wide_t sp_w, pv_w, lo, err, inner, norm, drv;
		bit    centred, hold;
		sp_w = s.sp;
		pv_w = s.pv;
		r = '0;
		if (s.op == OP_CLEAR) begin
			integ_acc = '0;
			prev_norm = bias_q;
			prev_pv = pv_w;
			return 1'b0;
		end
		if (s.op == OP_NOP)
			return 1'b0;
		centred = (s.op == OP_CENTERED);
		lo = centred ? -ONE_Q : wide_t'(0);
		err = span_units(sp_w, lo) - span_units(pv_w, lo);
		// anti-windup: freeze the integral while pegged and pushed further
		hold = (prev_norm >= ONE_Q && err > 0) || (prev_norm <= lo && err < 0);
		if (hold)
			held_count++;
		else
			integ_acc = clamp(integ_acc + err, ACC_LO, ACC_HI);
		inner = clamp(err + fixmul(integ_q, integ_acc), ACC_LO, ACC_HI);
		inner = clamp(inner - fixmul(deriv_q, pv_w - prev_pv), ACC_LO, ACC_HI);
		norm = fixmul(prop_q, inner);
		if (centred)
			norm = clamp(norm + bias_q, ACC_LO, ACC_HI);
		r.pegged_high = norm >= ONE_Q;
		r.pegged_low = norm <= lo;
		norm = clamp(norm, lo, ONE_Q);
		prev_norm = norm;
		prev_pv = pv_w;
		drv = (norm * scale_q) >>> FRAC;
		if (!centred)
			drv = drv + offset_q;
		drv = clamp(drv, I32_MIN, I32_MAX);
		r.drive = drv[31:0];
		r.error_value = err[26:0];
		return 1'b1;
	endfunction

	// raw value at a position in the input span (65536 = full span)
	function automatic logic signed [31:0] in_band(input longint frac16);
		longint span, x;
		span = (recip_q == 0) ? (64'sd1 <<< 33) : ((64'sd1 <<< 48) / longint'(recip_q));
		if (span > (64'sd1 <<< 33))
			span = 64'sd1 <<< 33;
		x = longint'(in_min_q) + ((frac16 * span) >>> 16);
		if (x > 64'sd2147483647)
			x = 64'sd2147483647;
		if (x < -64'sd2147483648)
			x = -64'sd2147483648;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] corner_value();
		case ($urandom_range(4))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0;
			3: return in_min_q[31:0];
			default: return -32'sd1;
		endcase
	endfunction

	// mostly a drifting measurement chasing stepped set points, plus noise
	function automatic sample_t make_sample();
		sample_t s;
		int      pick;
		pick = $urandom_range(99);
		if (pick < 4)
			s.op = OP_NOP;
		else if (pick < 12)
			s.op = OP_CLEAR;
		else if (pick < 56)
			s.op = OP_CENTERED;
		else
			s.op = OP_SPAN;
		pick = $urandom_range(99);
		if (pick < 70) begin
			if ($urandom_range(15) == 0)
				walk_sp = $urandom_range(0, 65536);
			walk_pv += longint'($urandom_range(0, 4096)) - 2048;
			if (walk_pv < -8192)
				walk_pv = -8192;
			if (walk_pv > 73728)
				walk_pv = 73728;
			s.sp = in_band(walk_sp);
			s.pv = in_band(walk_pv);
		end else if (pick < 90) begin
			s.sp = $urandom;
			s.pv = $urandom;
		end else begin
			s.sp = corner_value();
			s.pv = corner_value();
		end
		return s;
	endfunction

	function automatic longint pick_value(input reg_t idx, input cfg_mode_t mode);
		longint lo_v, hi_v, v;
		int     w;
		v = {$urandom, $urandom};
		case (idx)
			REG_IN_MIN, REG_OUT_OFFSET: begin
				lo_v = -(64'sd1 <<< 31);
				hi_v = (64'sd1 <<< 31) - 1;
				w = 32;
			end
			REG_IN_RECIP, REG_OUT_SCALE: begin
				lo_v = 0;
				hi_v = (64'sd1 <<< 31) - 1;
				w = 31;
			end
			// random draws stay inside the bias range
			REG_BIAS: begin
				lo_v = -(64'sd1 <<< 24);
				hi_v = 64'sd1 <<< 24;
				w = 25;
			end
			default: begin
				lo_v = -(64'sd1 <<< 47);
				hi_v = (64'sd1 <<< 47) - 1;
				w = 48;
			end
		endcase
		case (mode)
			CFG_TOP: return hi_v;
			CFG_BOTTOM: return lo_v;
			CFG_WILD: begin
				if (lo_v < 0)
					v = (v <<< (64 - w)) >>> (64 - w);
				else
					v = v & hi_v;
				return v;
			end
			default: begin
				case (idx)
					REG_IN_MIN: v = -longint'($urandom_range(0, 67108864));
					REG_IN_RECIP: v = $urandom_range(1 << 21, 1 << 24);
					REG_PROP_GAIN: begin
						v = $urandom_range(1 << 22, 1 << 26);
						if ($urandom_range(7) == 0)
							v = -v;
					end
					REG_INTEG_GAIN: v = $urandom_range(0, 1 << 23);
					REG_DERIV_GAIN: v = $urandom_range(0, 1 << 25);
					REG_BIAS: v = longint'($urandom_range(0, 1 << 25)) - (64'sd1 <<< 24);
					REG_OUT_SCALE: v = $urandom_range(0, 100 << 24);
					default: v = longint'($urandom_range(0, 100 << 24)) - (64'sd50 <<< 24);
				endcase
				return v;
			end
		endcase
	endfunction

	// register write, mirrored into the controller copy
	task automatic write_reg(input reg_t idx, input longint value);
		logic [47:0] data;
		data = value[47:0];
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_IN_MIN: in_min_q = sx(data, 32);
			REG_IN_RECIP: recip_q = data[30:0];
			REG_PROP_GAIN: prop_q = sx(data, 48);
			REG_INTEG_GAIN: integ_q = sx(data, 48);
			REG_DERIV_GAIN: deriv_q = sx(data, 48);
			REG_BIAS: bias_q = sx(data, 26);
			REG_OUT_SCALE: scale_q = data[30:0];
			default: offset_q = sx(data, 32);
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	task automatic queue_sample(input op_t op, input logic [31:0] sp, input logic [31:0] pv);
		sample_t s;
		s.op = op;
		s.sp = sp;
		s.pv = pv;
		samples_waiting.push_back(s);
	endtask

	// wait until every request is taken and answered, then let the block go idle
	task automatic drain_and_settle();
		while (samples_waiting.size() != 0 || s_tvalid || outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	// request driver: accept, predict, then offer the next request
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				accepted_count++;
				produced = controller_step(on_bus, next_out);
				if (produced)
					outputs_due.push_back(next_out);
			end
			if (!s_tvalid || s_tready) begin
				if (samples_waiting.size() != 0 && (steady_flow || $urandom_range(99) >= 14)) begin
					on_bus = samples_waiting.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {on_bus.pv, on_bus.sp};
					s_tuser <= on_bus.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= steady_flow || ($urandom_range(99) >= 14);
			if (m_tvalid && m_tready) begin
				got_out.drive = m_tdata[31:0];
				got_out.pegged_high = m_tdata[32];
				got_out.pegged_low = m_tdata[33];
				got_out.error_value = m_tdata[60:34];
				if (outputs_due.size() == 0) begin
					note_error($sformatf("unexpected result %h with nothing pending", m_tdata));
				end else begin
					want_out = outputs_due.pop_front();
					checked_count++;
					if (got_out.drive !== want_out.drive
							|| got_out.pegged_high !== want_out.pegged_high
							|| got_out.pegged_low !== want_out.pegged_low
							|| got_out.error_value !== want_out.error_value)
						note_error($sformatf(
							"result %0d: drive %h/%h high %b/%b low %b/%b err %h/%h (exp/got)",
							checked_count, want_out.drive, got_out.drive,
							want_out.pegged_high, got_out.pegged_high,
							want_out.pegged_low, got_out.pegged_low,
							want_out.error_value, got_out.error_value));
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus phases
	initial begin
		cfg_mode_t mode;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: ignored op, input extremes, clear
		queue_sample(OP_NOP, 32'sh7FFF_FFFF, 32'sh8000_0000);
		queue_sample(OP_CENTERED, 32'sh7FFF_FFFF, 32'sh8000_0000);
		queue_sample(OP_SPAN, 32'sh8000_0000, 32'sh7FFF_FFFF);
		queue_sample(OP_CENTERED, 32'sh0, 32'sh0);
		queue_sample(OP_CLEAR, 32'sh0, 32'sh1234_5678);
		drain_and_settle();

		// span of four from minus two, moderate gains, quarter bias
		write_reg(REG_IN_MIN, -(64'sd2 <<< 24));
		write_reg(REG_IN_RECIP, 64'sd1 <<< 22);
		write_reg(REG_PROP_GAIN, 64'sd2 <<< 24);
		write_reg(REG_INTEG_GAIN, 64'sd1 <<< 21);
		write_reg(REG_DERIV_GAIN, 64'sd1 <<< 23);
		write_reg(REG_BIAS, 64'sd1 <<< 22);
		write_reg(REG_OUT_SCALE, 64'sd10 <<< 24);
		write_reg(REG_OUT_OFFSET, -(64'sd5 <<< 24));
		close_writes();
		// clear preloads the bias, then drive into both limits and hold there
		queue_sample(OP_CLEAR, 32'sh0, 32'sh0);
		queue_sample(OP_CENTERED, Q_ONE, 32'sh0);
		repeat (3) queue_sample(OP_CENTERED, Q_TWO, -Q_TWO);
		queue_sample(OP_SPAN, Q_TWO, -Q_TWO);
		queue_sample(OP_NOP, 32'sh0, 32'sh0);
		repeat (2) queue_sample(OP_CENTERED, -Q_TWO, Q_TWO);
		queue_sample(OP_SPAN, -Q_TWO, Q_TWO);
		queue_sample(OP_CLEAR, 32'sh0, Q_ONE);
		queue_sample(OP_CENTERED, Q_ONE, Q_ONE);
		drain_and_settle();

		// full-scale output with top offset: drive saturation
		write_reg(REG_PROP_GAIN, (64'sd1 <<< 47) - 1);
		write_reg(REG_INTEG_GAIN, 64'sd0);
		write_reg(REG_DERIV_GAIN, 64'sd0);
		write_reg(REG_OUT_SCALE, (64'sd1 <<< 31) - 1);
		write_reg(REG_OUT_OFFSET, (64'sd1 <<< 31) - 1);
		close_writes();
		queue_sample(OP_SPAN, Q_TWO, -Q_TWO);
		queue_sample(OP_CENTERED, -Q_TWO, Q_TWO);
		queue_sample(OP_SPAN, Q_ONE, Q_ONE);
		drain_and_settle();

		// random phases, each under a fresh register setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				2, 6: mode = CFG_WILD;
				3: mode = CFG_TOP;
				5: mode = CFG_BOTTOM;
				default: mode = CFG_TYPICAL;
			endcase
			for (int i = 0; i < 8; i++)
				write_reg(reg_t'(i), pick_value(reg_t'(i), mode));
			close_writes();
			steady_flow = (phase == 4);
			walk_sp = $urandom_range(0, 65536);
			walk_pv = $urandom_range(0, 65536);
			for (int n = 0; n < PHASE_ITEMS; n++)
				samples_waiting.push_back(make_sample());
			drain_and_settle();
		end

		$display("run covered %0d requests and %0d checked results under %0d register settings,",
			accepted_count, checked_count, settings_count);
		$display("with the integral held against windup on %0d samples", held_count);
		if (error_count == 0 && outputs_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- pid_position_controller.f -----
src/pidc_pkg.sv
src/pid_position_controller.sv
bench/testbench.sv
